// ===== src/ipl4cs_pkg.sv =====
// types, constants and the end-around-carry adder shared by the checksum blocks
// no dependencies
package ipl4cs_pkg;

    // default depths of the front-to-back queue and of the result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    // transport kind codes
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_TCP   = 2'd1;
    localparam logic [1:0] KIND_UDP   = 2'd2;

    // ip protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // fixed ipv4 header offsets
    localparam logic [15:0] POS_IHL     = 16'd0;
    localparam logic [15:0] POS_TLEN_HI = 16'd2;
    localparam logic [15:0] POS_TLEN_LO = 16'd3;
    localparam logic [15:0] POS_PROTO   = 16'd9;
    localparam logic [15:0] POS_IP_CHK  = 16'd10;
    localparam logic [15:0] POS_ADDR_LO = 16'd12;
    localparam logic [15:0] POS_ADDR_HI = 16'd20;

    // smallest legal header length in 32-bit words
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

    // checksum field offsets inside the segment
    localparam logic [4:0] SEG_CHK_TCP = 5'd16;
    localparam logic [4:0] SEG_CHK_UDP = 5'd6;

    localparam logic [15:0] LAST_POS = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] header_checksum;
        logic [15:0] segment_checksum;
        logic [1:0]  transport_kind;
        logic        status;
    } t_out_item;

    // one classified byte: what to add to each sum, plus packet facts on the last byte
    typedef struct packed {
        logic        hdr_en;
        logic [15:0] hdr_word;
        logic        seg_en;
        logic [15:0] seg_word;
        logic        last;
        logic [1:0]  kind;
        logic [7:0]  proto;
        logic [15:0] seglen;
        logic        status;
    } t_word_op;

    // ones' complement add with one end-around carry fold
    function automatic logic [16:0] fold_add(input logic [16:0] sum, input logic [15:0] word);
        logic [17:0] t;
        t = {1'b0, sum} + {2'b00, word};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

endpackage

// ===== src/ipl4cs_queue.sv =====
// small first-word-fall-through queue with push/full and pop/empty sides
// depends on nothing but its parameters
module ipl4cs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a push");
`endif

endmodule

// ===== src/ipl4cs_front.sv =====
// front end: tracks byte position, learns header fields, classifies each byte
// into header and segment sum updates; uses ipl4cs_pkg
module ipl4cs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  ipl4cs_pkg::t_in_item  i_item,
    output ipl4cs_pkg::t_word_op  o_op
);

    logic [15:0] r_pos, n_pos;
    logic [3:0]  r_hw, n_hw;
    logic [15:0] r_tlen, n_tlen;
    logic [7:0]  r_proto, n_proto;
    logic [7:0]  r_pend, n_pend;

    logic [3:0]  hw_eff, hw_clip;
    logic [15:0] tlen_eff;
    logic [7:0]  proto_eff;
    logic [5:0]  hdr_bytes;
    logic [15:0] hdr_bytes_w;
    logic [1:0]  kind;
    logic [4:0]  chk_ofs;
    logic [6:0]  chk_pos;
    logic        odd, last;
    logic [15:0] hpos, word;
    logic [16:0] count;
    logic        hdr_en, in_addr, seg_body;

    always_comb begin
        last = i_item.last_byte;
        odd  = r_pos[0];

        // fields seen on this byte count already
        hw_eff    = (r_pos == ipl4cs_pkg::POS_IHL) ? i_item.data_byte[3:0] : r_hw;
        tlen_eff  = r_tlen;
        if (r_pos == ipl4cs_pkg::POS_TLEN_HI) begin
            tlen_eff = {i_item.data_byte, r_tlen[7:0]};
        end else if (r_pos == ipl4cs_pkg::POS_TLEN_LO) begin
            tlen_eff = {r_tlen[15:8], i_item.data_byte};
        end
        proto_eff = (r_pos == ipl4cs_pkg::POS_PROTO) ? i_item.data_byte : r_proto;

        hw_clip     = (hw_eff < ipl4cs_pkg::MIN_HDR_WORDS) ? ipl4cs_pkg::MIN_HDR_WORDS : hw_eff;
        hdr_bytes   = {hw_clip, 2'b00};
        hdr_bytes_w = {10'd0, hdr_bytes};

        if (proto_eff == ipl4cs_pkg::PROTO_TCP) begin
            kind = ipl4cs_pkg::KIND_TCP;
        end else if (proto_eff == ipl4cs_pkg::PROTO_UDP) begin
            kind = ipl4cs_pkg::KIND_UDP;
        end else begin
            kind = ipl4cs_pkg::KIND_OTHER;
        end
        chk_ofs = (kind == ipl4cs_pkg::KIND_TCP) ? ipl4cs_pkg::SEG_CHK_TCP
                                                 : ipl4cs_pkg::SEG_CHK_UDP;
        chk_pos = {1'b0, hdr_bytes} + {2'b00, chk_ofs};

        // word offset and value: an odd byte closes a word, an even last byte is zero padded
        hpos  = odd ? {r_pos[15:1], 1'b0} : r_pos;
        word  = odd ? {r_pend, i_item.data_byte} : {i_item.data_byte, 8'h00};
        count = {1'b0, r_pos} + 17'd1;

        hdr_en  = (odd || last) && (hpos < hdr_bytes_w);
        in_addr = (hpos >= ipl4cs_pkg::POS_ADDR_LO) && (hpos < ipl4cs_pkg::POS_ADDR_HI);
        seg_body = (kind != ipl4cs_pkg::KIND_OTHER) && (hpos >= hdr_bytes_w)
                   && (hpos < tlen_eff)
                   && (odd ? (r_pos < tlen_eff)
                           : ((count >= {1'b0, tlen_eff}) || last));

        o_op.hdr_en   = hdr_en;
        o_op.hdr_word = (hpos == ipl4cs_pkg::POS_IP_CHK) ? 16'd0 : word;
        // address words feed the pseudo header part of the segment sum
        o_op.seg_en   = (hdr_en && in_addr) || seg_body;
        o_op.seg_word = (seg_body && (hpos == {9'd0, chk_pos})) ? 16'd0 : word;
        o_op.last     = last;
        o_op.kind     = kind;
        o_op.proto    = proto_eff;
        o_op.seglen   = (tlen_eff > hdr_bytes_w) ? (tlen_eff - hdr_bytes_w) : 16'd0;
        o_op.status   = (count < {1'b0, tlen_eff}) || (count < {11'd0, hdr_bytes});
    end

    always_comb begin
        n_pos   = r_pos;
        n_hw    = r_hw;
        n_tlen  = r_tlen;
        n_proto = r_proto;
        n_pend  = r_pend;
        if (i_take) begin
            if (last) begin
                n_pos   = '0;
                n_hw    = '0;
                n_tlen  = '0;
                n_proto = '0;
                n_pend  = '0;
            end else begin
                n_pos   = (r_pos != ipl4cs_pkg::LAST_POS) ? r_pos + 16'd1 : r_pos;
                n_hw    = hw_eff;
                n_tlen  = tlen_eff;
                n_proto = proto_eff;
                n_pend  = odd ? r_pend : i_item.data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hw    <= '0;
            r_tlen  <= '0;
            r_proto <= '0;
            r_pend  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hw    <= n_hw;
            r_tlen  <= n_tlen;
            r_proto <= n_proto;
            r_pend  <= n_pend;
        end
    end

`ifndef NO_ASSERTIONS
    a_packet_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.last_byte) |=> (r_pos == '0 && r_tlen == '0 && r_proto == '0))
        else $error("front state not cleared after last byte");
`endif

endmodule

// ===== src/ipl4cs_back.sv =====
// back end: accumulates both ones' complement sums, finishes the checksums in
// two stages and queues the results; uses ipl4cs_pkg and ipl4cs_queue
module ipl4cs_back #(
    parameter int OUT_DEPTH = ipl4cs_pkg::OUT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipl4cs_pkg::t_word_op  i_op,
    input  logic                  i_op_avail,
    output logic                  o_op_take,
    output logic                  o_empty,
    input  logic                  i_pop,
    output ipl4cs_pkg::t_out_item o_result
);

    logic [16:0] r_hsum, r_ssum;
    logic [16:0] hsum_acc, ssum_acc;

    // finish stage b: folded sums and packet facts
    logic        r_b_valid;
    logic [16:0] r_b_hsum, r_b_ssum;
    logic [1:0]  r_b_kind;
    logic [7:0]  r_b_proto;
    logic [15:0] r_b_seglen;
    logic        r_b_status;

    // finish stage c: header checksum done, protocol added in
    logic        r_c_valid;
    logic [15:0] r_c_hc;
    logic [16:0] r_c_s1;
    logic [1:0]  r_c_kind;
    logic [15:0] r_c_seglen;
    logic        r_c_status;

    logic        oq_full;
    logic        b_ready, c_ready;
    logic [16:0] h1, s1, s2, s3;
    ipl4cs_pkg::t_out_item c_result;

    assign c_ready   = !r_c_valid || !oq_full;
    assign b_ready   = !r_b_valid || c_ready;
    assign o_op_take = i_op_avail && (!i_op.last || b_ready);

    always_comb begin
        hsum_acc = i_op.hdr_en ? ipl4cs_pkg::fold_add(r_hsum, i_op.hdr_word) : r_hsum;
        ssum_acc = i_op.seg_en ? ipl4cs_pkg::fold_add(r_ssum, i_op.seg_word) : r_ssum;
        h1       = ipl4cs_pkg::fold_add(r_b_hsum, 16'd0);
        s1       = ipl4cs_pkg::fold_add(r_b_ssum, {8'd0, r_b_proto});
        s2       = ipl4cs_pkg::fold_add(r_c_s1, r_c_seglen);
        s3       = ipl4cs_pkg::fold_add(s2, 16'd0);
        c_result.header_checksum  = r_c_hc;
        c_result.segment_checksum = (r_c_kind != ipl4cs_pkg::KIND_OTHER) ? ~s3[15:0] : 16'd0;
        c_result.transport_kind   = r_c_kind;
        c_result.status           = r_c_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsum    <= '0;
            r_ssum    <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (o_op_take) begin
                r_hsum <= i_op.last ? 17'd0 : hsum_acc;
                r_ssum <= i_op.last ? 17'd0 : ssum_acc;
            end
            if (o_op_take && i_op.last) begin
                r_b_valid <= 1'b1;
            end else if (c_ready) begin
                r_b_valid <= 1'b0;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_take && i_op.last) begin
            r_b_hsum   <= hsum_acc;
            r_b_ssum   <= ssum_acc;
            r_b_kind   <= i_op.kind;
            r_b_proto  <= i_op.proto;
            r_b_seglen <= i_op.seglen;
            r_b_status <= i_op.status;
        end
        if (c_ready) begin
            r_c_hc     <= ~h1[15:0];
            r_c_s1     <= s1;
            r_c_kind   <= r_b_kind;
            r_c_seglen <= r_b_seglen;
            r_c_status <= r_b_status;
        end
    end

    ipl4cs_queue #(
        .WIDTH ($bits(ipl4cs_pkg::t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_c_valid),
        .i_data  (c_result),
        .o_full  (oq_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_result)
    );

`ifndef NO_ASSERTIONS
    a_sums_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_take && i_op.last) |=> (r_hsum == '0 && r_ssum == '0 && r_b_valid))
        else $error("sums not restarted after last byte");
    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && oq_full) |=> (r_c_valid && $stable(r_c_hc) && $stable(r_c_s1)))
        else $error("finish stage lost a result while the result queue was full");
`endif

endmodule

// ===== src/ipv4_l4_checksum_recompute.sv =====
// top level of the ipv4 header and tcp/udp checksum generator
// uses ipl4cs_pkg, ipl4cs_front, ipl4cs_queue and ipl4cs_back
//
// Feed an IPv4 packet one byte per transfer on the input queue side (push/full),
// starting at the first header byte, and mark the final byte with last_byte.
// One result per packet comes out on the result queue side (empty/pop): the
// IPv4 header checksum and the TCP or UDP checksum over segment plus pseudo
// header, both computed with their check fields as zero, the transport kind
// (other, tcp, udp) and a status bit set when the packet ended before its
// total length or its header. Bytes past the total length are ignored and an
// odd tail is zero padded; a udp value of zero is given as zero. The block
// takes one byte every clock cycle while full is low, whatever the packet
// sizes, so a one-byte packet may follow in the next cycle. Each byte is
// classified in the front end in the cycle of its transfer and needs one
// end-around-carry add per sum in the back end; the packet result passes
// stages b and c and the result queue. A queue of QUEUE_DEPTH byte entries
// lets the front keep taking bytes while the back waits on a full result
// queue of OUT_DEPTH entries; full rises only once both queues have filled.
module ipv4_l4_checksum_recompute #(
    parameter int QUEUE_DEPTH = ipl4cs_pkg::QUEUE_DEPTH,
    parameter int OUT_DEPTH   = ipl4cs_pkg::OUT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input queue side
    input  logic                  push,
    output logic                  full,
    input  ipl4cs_pkg::t_in_item  i_item,
    // result queue side
    output logic                  empty,
    input  logic                  pop,
    output ipl4cs_pkg::t_out_item o_result
);

    ipl4cs_pkg::t_word_op front_op;
    ipl4cs_pkg::t_word_op queue_op;
    logic                 take;
    logic                 queue_empty;
    logic                 back_take;

    // a byte transfer happens when push is high and the byte queue has room
    assign take = push && !full;

    // classify the byte against what is known of the header so far
    ipl4cs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .o_op    (front_op)
    );

    // decouples classification from accumulation
    ipl4cs_queue #(
        .WIDTH ($bits(ipl4cs_pkg::t_word_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (front_op),
        .o_full  (full),
        .o_empty (queue_empty),
        .i_pop   (back_take),
        .o_data  (queue_op)
    );

    // accumulate, finish and queue results
    ipl4cs_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (queue_op),
        .i_op_avail (!queue_empty),
        .o_op_take  (back_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

// ===== sim/tb_ipv4_l4_checksum_recompute.sv =====
// testbench for ipv4_l4_checksum_recompute: random and directed ipv4 packets, byte per transfer
// depends on ipl4cs_pkg and the rtl under src; self checking against an internal checksum predictor
module tb_ipv4_l4_checksum_recompute;

    // cycles with no transfer on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // extra wait at the end, once all results are back
    localparam int TAIL_CYCLES    = 16;
    // per phase stimulus budget
    localparam int PHASE_BYTES    = 180;
    localparam int PHASE_PACKETS  = 4;
    // length of the packet that claims the largest total length
    localparam int LONG_BYTES     = 120;

    // checksum predictor plus the queue of checksums still owed by the block
    class checksum_scoreboard;
        int unsigned next_pos;
        int unsigned ihl_words;
        int unsigned proto_num;
        int unsigned ip_total_len;
        int unsigned hdr_acc;
        int unsigned seg_acc;
        int unsigned high_byte;
        ipl4cs_pkg::t_out_item due_checksums[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned tcp_seen;
        int unsigned udp_seen;
        int unsigned other_seen;
        int unsigned short_seen;

        function new();
            restart();
        endfunction

        function void restart();
            next_pos     = 0;
            ihl_words    = 0;
            proto_num    = 0;
            ip_total_len = 0;
            hdr_acc      = 0;
            seg_acc      = 0;
            high_byte    = 0;
        endfunction

        function int unsigned pending();
            return due_checksums.size();
        endfunction

        // ones' complement add, one end-around fold
        function int unsigned carry_add(int unsigned acc, int unsigned word);
            acc = acc + (word & 32'hFFFF);
            return (acc & 32'hFFFF) + (acc >> 16);
        endfunction

        function int unsigned hdr_len();
            int unsigned w;
            w = ihl_words & 32'hF;
            if (w < ipl4cs_pkg::MIN_HDR_WORDS)
                w = ipl4cs_pkg::MIN_HDR_WORDS;
            return w * 4;
        endfunction

        function logic [1:0] kind_now();
            if (proto_num == ipl4cs_pkg::PROTO_TCP)
                return ipl4cs_pkg::KIND_TCP;
            if (proto_num == ipl4cs_pkg::PROTO_UDP)
                return ipl4cs_pkg::KIND_UDP;
            return ipl4cs_pkg::KIND_OTHER;
        endfunction

        // header word; the address words also feed the pseudo header
        function void add_hdr_word(int unsigned hpos, int unsigned word);
            if (hpos >= hdr_len())
                return;
            if (hpos >= ipl4cs_pkg::POS_ADDR_LO && hpos < ipl4cs_pkg::POS_ADDR_HI)
                seg_acc = carry_add(seg_acc, word);
            if (hpos == ipl4cs_pkg::POS_IP_CHK)
                word = 0;
            hdr_acc = carry_add(hdr_acc, word);
        endfunction

        function void add_seg_word(int unsigned hpos, int unsigned word);
            int unsigned hb;
            int unsigned chk;
            logic [1:0]  k;
            hb = hdr_len();
            k  = kind_now();
            if (k == ipl4cs_pkg::KIND_OTHER || hpos < hb || hpos >= ip_total_len)
                return;
            chk = (k == ipl4cs_pkg::KIND_TCP) ? ipl4cs_pkg::SEG_CHK_TCP
                                              : ipl4cs_pkg::SEG_CHK_UDP;
            if (hpos - hb == chk)
                word = 0;
            seg_acc = carry_add(seg_acc, word);
        endfunction

        // accepted input byte: advance the sums, queue a result on the last byte
        function void note_byte(ipl4cs_pkg::t_in_item it);
            int unsigned b;
            int unsigned p;
            int unsigned word;
            int unsigned hb;
            int unsigned seglen;
            int unsigned hc;
            int unsigned sc;
            int unsigned acc;
            logic [1:0]  k;
            ipl4cs_pkg::t_out_item res;
            b = it.data_byte;
            p = next_pos;
            if (p == ipl4cs_pkg::POS_IHL)
                ihl_words = b & 32'hF;
            else if (p == ipl4cs_pkg::POS_TLEN_HI)
                ip_total_len = (ip_total_len & 32'hFF) | (b << 8);
            else if (p == ipl4cs_pkg::POS_TLEN_LO)
                ip_total_len = (ip_total_len & 32'hFF00) | b;
            else if (p == ipl4cs_pkg::POS_PROTO)
                proto_num = b;

            if ((p % 2) != 0) begin
                word = (high_byte << 8) | b;
                add_hdr_word(p - 1, word);
                if (p < ip_total_len)
                    add_seg_word(p - 1, word);
            end else begin
                high_byte = b;
                // odd segment tail, zero padded
                if (p + 1 >= ip_total_len)
                    add_seg_word(p, b << 8);
                // packet ends on an even position, pad likewise
                if (it.last_byte) begin
                    add_hdr_word(p, b << 8);
                    if (p + 1 < ip_total_len)
                        add_seg_word(p, b << 8);
                end
            end

            if (!it.last_byte) begin
                if (next_pos < ipl4cs_pkg::LAST_POS)
                    next_pos++;
                return;
            end

            hb     = hdr_len();
            k      = kind_now();
            seglen = (ip_total_len > hb) ? ip_total_len - hb : 0;
            hc     = ~carry_add(hdr_acc, 0) & 32'hFFFF;
            if (k != ipl4cs_pkg::KIND_OTHER) begin
                acc = carry_add(seg_acc, proto_num);
                acc = carry_add(acc, seglen);
                acc = carry_add(acc, 0);
                sc  = ~acc & 32'hFFFF;
            end else begin
                sc = 0;
            end
            res.header_checksum  = 16'(hc);
            res.segment_checksum = 16'(sc);
            res.transport_kind   = k;
            res.status           = (p + 1 < ip_total_len) || (p + 1 < hb);
            due_checksums.push_back(res);
            restart();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(ipl4cs_pkg::t_out_item got);
            ipl4cs_pkg::t_out_item want;
            if (due_checksums.size() == 0) begin
                report_mismatch($sformatf("result %h with no packet outstanding", got));
                return;
            end
            want = due_checksums.pop_front();
            checked++;
            if (got.header_checksum !== want.header_checksum)
                report_mismatch($sformatf("header checksum %h, want %h",
                                          got.header_checksum, want.header_checksum));
            if (got.segment_checksum !== want.segment_checksum)
                report_mismatch($sformatf("segment checksum %h, want %h",
                                          got.segment_checksum, want.segment_checksum));
            if (got.transport_kind !== want.transport_kind)
                report_mismatch($sformatf("transport kind %0d, want %0d",
                                          got.transport_kind, want.transport_kind));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
            case (want.transport_kind)
                ipl4cs_pkg::KIND_TCP: tcp_seen++;
                ipl4cs_pkg::KIND_UDP: udp_seen++;
                default:              other_seen++;
            endcase
            if (want.status)
                short_seen++;
        endtask
    endclass

    // dut hookup; every input known from time zero
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    ipl4cs_pkg::t_in_item  i_item  = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    ipl4cs_pkg::t_out_item o_result;

    ipv4_l4_checksum_recompute u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    checksum_scoreboard sb = new();

    // idling odds in percent, changed per phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned bytes_sent   = 0;
    int unsigned packets_sent = 0;
    int unsigned idle_cycles  = 0;

    // packet under construction, sent front to back
    logic [7:0] pkt_bytes[$];

    // result side: check at the edge with the pre-edge pop, then pick the next pop
    always @(posedge i_clk) begin
        if (pop && !empty)
            sb.check_result(o_result);
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles where neither side completes a transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one byte transfer; push stays high on return so back to back bytes need no gap
    task automatic send_byte(ipl4cs_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do
            @(posedge i_clk);
        while (full);
        sb.note_byte(it);
        bytes_sent++;
    endtask

    task automatic send_packet();
        ipl4cs_pkg::t_in_item it;
        foreach (pkt_bytes[k]) begin
            it.data_byte = pkt_bytes[k];
            it.last_byte = (k == pkt_bytes.size() - 1);
            send_byte(it);
        end
        packets_sent++;
    endtask

    // mostly well formed packets with random content, the rest damaged or plain noise
    task automatic make_packet();
        int unsigned shape;
        int unsigned words;
        int unsigned hb;
        int unsigned seglen;
        int unsigned total;
        int unsigned cut;
        int unsigned n;
        logic [7:0]  proto;
        pkt_bytes.delete();
        shape = $urandom_range(99);
        if (shape >= 90) begin
            // noise: any length, any bytes
            n = $urandom_range(1, 12);
            repeat (n) pkt_bytes.push_back(8'($urandom));
            return;
        end
        // header length field, now and then out of the usual five words (below five too)
        words = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : 5;
        hb    = ((words < ipl4cs_pkg::MIN_HDR_WORDS) ? ipl4cs_pkg::MIN_HDR_WORDS : words) * 4;
        case ($urandom_range(9))
            0, 1, 2, 3: proto = ipl4cs_pkg::PROTO_TCP;
            4, 5, 6, 7: proto = ipl4cs_pkg::PROTO_UDP;
            default:    proto = 8'($urandom);
        endcase
        // short segments keep results frequent, a few longer ones for carries
        seglen = ($urandom_range(19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        total  = hb + seglen;
        for (n = 0; n < total; n++)
            pkt_bytes.push_back(8'($urandom));
        pkt_bytes[ipl4cs_pkg::POS_IHL]     = {4'($urandom), 4'(words)};
        pkt_bytes[ipl4cs_pkg::POS_TLEN_HI] = 8'(total >> 8);
        pkt_bytes[ipl4cs_pkg::POS_TLEN_LO] = 8'(total);
        pkt_bytes[ipl4cs_pkg::POS_PROTO]   = proto;
        if (shape >= 65 && shape < 75) begin
            // junk past the total length
            n = $urandom_range(1, 8);
            repeat (n) pkt_bytes.push_back(8'($urandom));
        end else if (shape >= 75 && shape < 85) begin
            // packet cut short, possibly inside the header
            cut = $urandom_range(1, total - 1);
            while (pkt_bytes.size() > cut)
                void'(pkt_bytes.pop_back());
        end else if (shape >= 85) begin
            // total length claims no more than the header
            n = $urandom_range(0, hb);
            pkt_bytes[ipl4cs_pkg::POS_TLEN_HI] = 8'(n >> 8);
            pkt_bytes[ipl4cs_pkg::POS_TLEN_LO] = 8'(n);
        end
    endtask

    // random packets under one idling pattern, then hold off until all results are back
    task automatic run_phase(int unsigned send_pct, int unsigned stall_pct);
        int unsigned phase_bytes;
        int unsigned phase_pkts;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        phase_bytes    = 0;
        phase_pkts     = 0;
        while (phase_bytes < PHASE_BYTES || phase_pkts < PHASE_PACKETS) begin
            make_packet();
            phase_bytes += pkt_bytes.size();
            phase_pkts++;
            send_packet();
        end
        push <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    initial begin
        int unsigned n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a lone all-ones byte (header words 15, ends at once)
        pkt_bytes = '{8'hFF};
        send_packet();
        // a lone zero byte
        pkt_bytes = '{8'h00};
        send_packet();
        // udp, header length field below five, odd one-byte segment, all-ones
        // content so the check fields matter and the sums carry on every add
        pkt_bytes.delete();
        repeat (21) pkt_bytes.push_back(8'hFF);
        pkt_bytes[ipl4cs_pkg::POS_IHL]     = 8'h44;
        pkt_bytes[ipl4cs_pkg::POS_TLEN_HI] = 8'h00;
        pkt_bytes[ipl4cs_pkg::POS_TLEN_LO] = 8'd21;
        pkt_bytes[ipl4cs_pkg::POS_PROTO]   = ipl4cs_pkg::PROTO_UDP;
        send_packet();

        // back to back, no idling on either side
        run_phase(0, 0);

        // largest total length, packet ends far short of it
        pkt_bytes.delete();
        for (n = 0; n < LONG_BYTES; n++)
            pkt_bytes.push_back(8'($urandom));
        pkt_bytes[ipl4cs_pkg::POS_IHL]     = 8'h45;
        pkt_bytes[ipl4cs_pkg::POS_TLEN_HI] = 8'hFF;
        pkt_bytes[ipl4cs_pkg::POS_TLEN_LO] = 8'hFF;
        pkt_bytes[ipl4cs_pkg::POS_PROTO]   = ipl4cs_pkg::PROTO_UDP;
        send_packet();

        run_phase(66, 0);
        run_phase(0, 66);
        run_phase(38, 38);

        // drain with an eager receiver so a stray result would still show up
        push <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d packets in %0d bytes, %0d results checked: tcp %0d udp %0d other %0d",
                 packets_sent, bytes_sent, sb.checked, sb.tcp_seen, sb.udp_seen, sb.other_seen);
        $display("%0d results flagged short, %0d mismatches, four idling patterns",
                 sb.short_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ipl4cs_pkg.sv
src/ipl4cs_queue.sv
src/ipl4cs_front.sv
src/ipl4cs_back.sv
src/ipv4_l4_checksum_recompute.sv
sim/tb_ipv4_l4_checksum_recompute.sv
